/* rtl/pocnt_pkg.sv */
// ----------------------------------------------------------------------------
// pocnt_pkg
// Shared constants, codes and types of the partition overlap counter.
// ----------------------------------------------------------------------------
package pocnt_pkg;

  // Store geometry
  localparam int MAX_TAXA  = 256;
  localparam int MAX_PARTS = 64;
  localparam int TAXA_AW   = $clog2(MAX_TAXA);
  localparam int CNT_W     = $clog2(MAX_TAXA + 1);
  localparam int PART_AW   = $clog2(MAX_PARTS);

  // Field widths
  localparam int CMD_W  = 2;
  localparam int PART_W = 6;
  localparam int CFG_W  = 7;
  localparam int OVL_W  = 9;
  localparam int ST_W   = 2;

  localparam int OVL_MAX    = 511;
  localparam int SAT_W      = (CNT_W > OVL_W) ? CNT_W : OVL_W;
  localparam int CFG_RESET  = 64;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_DROPPED   = 2'd2
  } status_e;

  // Work handed to the back end
  typedef enum logic [1:0] {
    OP_WRITE,   // store one row
    OP_COUNT,   // sweep rows and count overlap
    OP_FIXED    // result known up front, overlap zero
  } op_kind_e;

  typedef struct packed {
    op_kind_e               kind;
    logic [MAX_PARTS-1:0]   row;
    logic [TAXA_AW-1:0]     addr;
    logic [PART_W-1:0]      part_a;
    logic [PART_W-1:0]      part_b;
    logic [CNT_W-1:0]       rows;
    status_e                status;
  } op_t;

  // Clamp a count to the 9-bit result field
  function automatic logic [OVL_W-1:0] sat_overlap(input logic [CNT_W-1:0] c);
    logic [SAT_W-1:0] wide;
    wide = SAT_W'(c);
    if (wide > SAT_W'(OVL_MAX)) begin
      return OVL_W'(OVL_MAX);
    end
    return OVL_W'(wide);
  endfunction

endpackage

/* rtl/pocnt_in_if.sv */
// ----------------------------------------------------------------------------
// pocnt_in_if
// Command channel: valid/ready handshake with one command word.
// ----------------------------------------------------------------------------
interface pocnt_in_if
  import pocnt_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [MAX_PARTS-1:0] row_bits;
  logic [PART_W-1:0]    part_a;
  logic [PART_W-1:0]    part_b;

  modport source (output valid, cmd, row_bits, part_a, part_b, input ready);
  modport sink   (input valid, cmd, row_bits, part_a, part_b, output ready);
endinterface

/* rtl/pocnt_out_if.sv */
// ----------------------------------------------------------------------------
// pocnt_out_if
// Result channel: valid/ready handshake with one overlap word.
// ----------------------------------------------------------------------------
interface pocnt_out_if
  import pocnt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OVL_W-1:0] overlap;
  logic [ST_W-1:0]  status;

  modport source (output valid, overlap, status, input ready);
  modport sink   (input valid, overlap, status, output ready);
endinterface

/* rtl/pocnt_front.sv */
// ----------------------------------------------------------------------------
// pocnt_front
// Accepts command words, keeps row count and drop flag, classifies each
// command and pushes store, count or fixed-result work into the queue.
// ----------------------------------------------------------------------------
module pocnt_front
  import pocnt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  pocnt_in_if.sink         in_s,
  input  logic [CFG_W-1:0] parts_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output op_t              q_op_o
);

  logic [CNT_W-1:0]     row_cnt_q, row_cnt_d;
  logic                 dropped_q, dropped_d;
  logic [CFG_W-1:0]     np;
  logic [MAX_PARTS-1:0] mask;
  logic                 accept;
  logic                 full;
  logic                 bad_idx;
  cmd_e                 cmd;

  assign in_s.ready = !q_full_i;
  assign accept     = in_s.valid && in_s.ready;
  assign cmd        = cmd_e'(in_s.cmd);
  assign full       = (row_cnt_q == CNT_W'(MAX_TAXA));

  // Effective partition count and column mask
  assign np = (parts_i > CFG_W'(MAX_PARTS)) ? CFG_W'(MAX_PARTS) : parts_i;
  always_comb begin
    for (int p = 0; p < MAX_PARTS; p++) begin
      mask[p] = (CFG_W'(p) < np);
    end
  end

  assign bad_idx = ({1'b0, in_s.part_a} >= np) || ({1'b0, in_s.part_b} >= np);

  // Classify
  always_comb begin
    row_cnt_d      = row_cnt_q;
    dropped_d      = dropped_q;
    q_push_o       = 1'b0;
    q_op_o.kind    = OP_FIXED;
    q_op_o.row     = in_s.row_bits & mask;
    q_op_o.addr    = row_cnt_q[TAXA_AW-1:0];
    q_op_o.part_a  = in_s.part_a;
    q_op_o.part_b  = in_s.part_b;
    q_op_o.rows    = row_cnt_q;
    q_op_o.status  = dropped_q ? ST_DROPPED : ST_OK;
    if (accept) begin
      case (cmd)
        CMD_CLEAR: begin
          row_cnt_d = '0;
          dropped_d = 1'b0;
        end
        CMD_APPEND: begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            q_push_o    = 1'b1;
            q_op_o.kind = OP_WRITE;
            row_cnt_d   = row_cnt_q + CNT_W'(1);
          end
        end
        CMD_QUERY: begin
          q_push_o = 1'b1;
          if (bad_idx) begin
            q_op_o.status = ST_BAD_INDEX;
          end else if (in_s.part_a != in_s.part_b) begin
            q_op_o.kind = OP_COUNT;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      dropped_q <= 1'b0;
    end else begin
      row_cnt_q <= row_cnt_d;
      dropped_q <= dropped_d;
    end
  end

endmodule

/* rtl/pocnt_fifo.sv */
// ----------------------------------------------------------------------------
// pocnt_fifo
// Short work queue between front and back end.
// ----------------------------------------------------------------------------
module pocnt_fifo
  import pocnt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  op_o,
  output logic empty_o
);

  op_t             slot_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == Q_CW'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign op_o    = slot_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + Q_CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - Q_CW'(1);
      end
    end
  end

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

/* rtl/pocnt_back.sv */
// ----------------------------------------------------------------------------
// pocnt_back
// Row memory and overlap engine: stores rows, sweeps stored rows for a
// query, counts rows with both partition bits set, holds the result word.
// ----------------------------------------------------------------------------
module pocnt_back
  import pocnt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  op_t       op_i,
  input  logic      empty_i,
  output logic      pop_o,
  pocnt_out_if.source out_s
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DONE
  } state_e;

  // Row memory, one word per taxon
  logic [MAX_PARTS-1:0] mem [MAX_TAXA];
  logic [MAX_PARTS-1:0] rd_data_q;

  state_e            state_q;
  logic [CNT_W-1:0]  issue_q;
  logic [CNT_W-1:0]  rows_q;
  logic [CNT_W-1:0]  acc_q;
  logic              rd_vld_q;
  logic [PART_W-1:0] pa_q, pb_q;
  status_e           st_q;
  logic              out_valid_q;
  logic [OVL_W-1:0]  ovl_q;
  status_e           out_st_q;

  logic mem_we, rd_en, load, hit;

  assign pop_o  = (state_q == S_IDLE) && !empty_i;
  assign mem_we = pop_o && (op_i.kind == OP_WRITE);
  assign rd_en  = (state_q == S_SWEEP) && (issue_q < rows_q);
  assign load   = (state_q == S_DONE) && (!out_valid_q || out_s.ready);
  assign hit    = rd_data_q[pa_q[PART_AW-1:0]] & rd_data_q[pb_q[PART_AW-1:0]];

  assign out_s.valid   = out_valid_q;
  assign out_s.overlap = ovl_q;
  assign out_s.status  = out_st_q;

  // Memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[op_i.addr] <= op_i.row;
    end
    if (rd_en) begin
      rd_data_q <= mem[issue_q[TAXA_AW-1:0]];
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      issue_q     <= '0;
      rows_q      <= '0;
      acc_q       <= '0;
      pa_q        <= '0;
      pb_q        <= '0;
      st_q        <= ST_OK;
      ovl_q       <= '0;
      out_st_q    <= ST_OK;
    end else begin
      if (out_valid_q && out_s.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            acc_q   <= '0;
            issue_q <= '0;
            rows_q  <= op_i.rows;
            pa_q    <= op_i.part_a;
            pb_q    <= op_i.part_b;
            st_q    <= op_i.status;
            case (op_i.kind)
              OP_COUNT: state_q <= S_SWEEP;
              OP_FIXED: state_q <= S_DONE;
              default:  state_q <= S_IDLE;
            endcase
          end
        end
        S_SWEEP: begin
          rd_vld_q <= rd_en;
          if (rd_en) begin
            issue_q <= issue_q + CNT_W'(1);
          end
          if (rd_vld_q) begin
            acc_q <= acc_q + CNT_W'(hit);
          end
          if (!rd_en && !rd_vld_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            out_valid_q <= 1'b1;
            ovl_q       <= sat_overlap(acc_q);
            out_st_q    <= st_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rd_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == S_SWEEP)
    else $error("read data pending outside sweep");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWEEP |-> issue_q <= rows_q)
    else $error("sweep ran past stored rows");

  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWEEP |-> acc_q <= issue_q)
    else $error("overlap count exceeds rows read");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !pop_o)
    else $error("queue popped while engine busy");
`endif

endmodule

/* rtl/partition_overlap_counter_top.sv */
// ----------------------------------------------------------------------------
// partition_overlap_counter_top
// Taxon-by-partition presence store with pairwise overlap counting.
// ----------------------------------------------------------------------------
// Usage:
//   in_s carries one command word: clear, append a taxon row, or query the
//   overlap of two partitions. out_s gives one word (overlap, status) for
//   each query; clear and append give none.
//   cfg_we_i/cfg_data_i write parts_in_use, only while the block is idle.
// Timing:
//   Clear and append are taken one per cycle while the two-entry work queue
//   has room. A query sweeps the stored rows through the row memory's single
//   read port, one row per cycle, and the next queued work waits for that
//   sweep. Bad-index and same-partition queries skip the sweep.
// Reset: row count, drop flag and queue are cleared, parts_in_use returns
//   to 64; the row memory needs no clearing since only rows below the
//   count are ever read.
// Stall: a result waits in the output register; the engine holds its next
//   result, then the queue fills and in_s.ready drops.
// ----------------------------------------------------------------------------
module partition_overlap_counter_top
  import pocnt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  pocnt_in_if.sink         in_s,
  pocnt_out_if.source      out_s,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [CFG_W-1:0] parts_q;
  logic             q_push, q_full, q_pop, q_empty;
  op_t              q_in, q_out;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parts_q <= CFG_W'(CFG_RESET);
    end else if (cfg_we_i) begin
      parts_q <= cfg_data_i;
    end
  end

  pocnt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_s     (in_s),
    .parts_i  (parts_q),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_op_o   (q_in)
  );

  pocnt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .op_o    (q_out),
    .empty_o (q_empty)
  );

  pocnt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (q_out),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .out_s   (out_s)
  );

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks partition_overlap_counter_top against its own overlap predictor.
// A short table of commands with hand-worked results runs first: empty
// store, full-width rows, same partition, bad index, width 0/1/saturated,
// store overflow. Random command sequences follow, with random stalls on
// both channels and long result hold-offs.
// ----------------------------------------------------------------------------
module testbench
  import pocnt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_WORDS = 1200;
  localparam int          LONG_HOLD    = 400;
  localparam int          SETTLE_CYC   = 8;
  localparam int          TAIL_CYC     = MAX_TAXA + 16;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  typedef struct {
    cmd_e                 cmd;
    logic [MAX_PARTS-1:0] row;
    logic [PART_W-1:0]    pa;
    logic [PART_W-1:0]    pb;
  } word_t;

  typedef struct {
    logic [OVL_W-1:0] ovl;
    status_e          st;
  } overlap_t;

  typedef struct {
    bit               cfg_row;
    logic [CFG_W-1:0] cfg_val;
    word_t            w;
    int               reps;
    bit               typed;
    overlap_t         want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  pocnt_in_if  in_if ();
  pocnt_out_if out_if ();

  partition_overlap_counter_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_if),
    .out_s      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  // Predictor state: rows kept as words, masked to the width at append time
  logic [MAX_PARTS-1:0] taxon_rows [MAX_TAXA];
  int unsigned          taxa_stored;
  bit                   rows_dropped;
  logic [CFG_W-1:0]     parts_cfg;

  overlap_t    pending_overlaps [$];
  overlap_t    want_none;
  plan_row_t   plan [$];
  int unsigned error_count;
  int unsigned words_sent;
  int unsigned cycle_count;
  bit          hold_req;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic int unsigned usable_parts();
    return (parts_cfg > CFG_W'(MAX_PARTS)) ? MAX_PARTS : int'(parts_cfg);
  endfunction

  // Update predicted state for one word; returns 1 when it yields a result
  function automatic bit predict_overlap(input word_t w, output overlap_t r);
    int unsigned          np;
    int unsigned          cnt;
    logic [MAX_PARTS-1:0] mask;
    np = usable_parts();
    // shift by 64 wraps to zero, so the mask is all ones at full width
    mask = (MAX_PARTS'(1) << np) - MAX_PARTS'(1);
    r = want_none;
    case (w.cmd)
      CMD_CLEAR: begin
        taxa_stored  = 0;
        rows_dropped = 1'b0;
      end
      CMD_APPEND: begin
        if (taxa_stored >= MAX_TAXA) begin
          rows_dropped = 1'b1;
        end else begin
          taxon_rows[taxa_stored] = w.row & mask;
          taxa_stored++;
        end
      end
      CMD_QUERY: begin
        if (w.pa >= np || w.pb >= np) begin
          r.ovl = '0;
          r.st  = ST_BAD_INDEX;
        end else begin
          cnt = 0;
          if (w.pa != w.pb) begin
            for (int i = 0; i < taxa_stored; i++) begin
              cnt += int'(taxon_rows[i][w.pa] & taxon_rows[i][w.pb]);
            end
          end
          r.ovl = (cnt > OVL_MAX) ? OVL_W'(OVL_MAX) : OVL_W'(cnt);
          r.st  = rows_dropped ? ST_DROPPED : ST_OK;
        end
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Offer one word until taken, then predict; called and returns at a clock edge
  task automatic send_word(input word_t w, input bit typed, input overlap_t want);
    overlap_t r;
    in_if.valid    <= 1'b1;
    in_if.cmd      <= w.cmd;
    in_if.row_bits <= w.row;
    in_if.part_a   <= w.pa;
    in_if.part_b   <= w.pb;
    do @(posedge clk_i); while (!in_if.ready);
    if (w.cmd != CMD_NONE) words_sent++;
    if (predict_overlap(w, r)) begin
      if (typed) r = want;
      pending_overlaps = {pending_overlaps, r};
    end
  endtask

  // Random idle on the command side, mostly short
  task automatic sender_gap(input bit steady);
    int unsigned n;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55) n = 0;
    else if (pick < 90) n = $urandom_range(1, 3);
    else if (pick < 98) n = $urandom_range(4, 10);
    else n = $urandom_range(20, 40);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every query has answered
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_overlaps.size() != 0) @(posedge clk_i);
  endtask

  // Width register write, only with the block idle
  task automatic write_parts(input logic [CFG_W-1:0] v);
    settle();
    // appends may still sit in the work queue
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    parts_cfg = v;
  endtask

  function automatic logic [MAX_PARTS-1:0] random_row();
    logic [MAX_PARTS-1:0] a;
    logic [MAX_PARTS-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      2: return a & b;
      3: return a | b;
      4: return MAX_PARTS'(1) << $urandom_range(0, MAX_PARTS - 1);
      default: return a;
    endcase
  endfunction

  function automatic logic [PART_W-1:0] pick_part();
    int unsigned np;
    np = usable_parts();
    if (np != 0 && $urandom_range(0, 9) != 0) begin
      return PART_W'($urandom_range(0, np - 1));
    end
    return PART_W'($urandom_range(0, MAX_PARTS - 1));
  endfunction

  function automatic word_t make_query();
    word_t w;
    w.cmd = CMD_QUERY;
    w.row = random_row();
    w.pa  = pick_part();
    w.pb  = ($urandom_range(0, 9) == 0) ? w.pa : pick_part();
    return w;
  endfunction

  function automatic word_t make_word(input cmd_e c);
    word_t w;
    w.cmd = c;
    w.row = random_row();
    w.pa  = PART_W'($urandom_range(0, MAX_PARTS - 1));
    w.pb  = PART_W'($urandom_range(0, MAX_PARTS - 1));
    return w;
  endfunction

  function automatic logic [CFG_W-1:0] pick_cfg();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CFG_W'(1);
      2: return CFG_W'(MAX_PARTS);
      3: return '1;
      4: return CFG_W'($urandom_range(MAX_PARTS + 1, 126));
      default: return CFG_W'($urandom_range(2, MAX_PARTS - 1));
    endcase
  endfunction

  // Table row builders
  function automatic plan_row_t cfg_step(input logic [CFG_W-1:0] v);
    plan_row_t p;
    p = '{1'b1, v, make_word(CMD_NONE), 0, 1'b0, want_none};
    return p;
  endfunction

  function automatic plan_row_t cmd_step(input cmd_e c, input logic [MAX_PARTS-1:0] row,
                                         input int reps);
    plan_row_t p;
    p = '{1'b0, '0, make_word(c), reps, 1'b0, want_none};
    p.w.row = row;
    return p;
  endfunction

  function automatic plan_row_t query_step(input int a, input int b, input bit typed,
                                           input int ovl, input status_e st);
    plan_row_t p;
    p = '{1'b0, '0, make_word(CMD_QUERY), 1, typed, '{OVL_W'(ovl), st}};
    p.w.pa = PART_W'(a);
    p.w.pb = PART_W'(b);
    return p;
  endfunction

  // Append one row to the end of the table
  function automatic void add_step(input plan_row_t p);
    plan = {plan, p};
  endfunction

  // Result receiver: random ready, one long hold-off on request
  initial begin : result_sink
    bit          lvl;
    int unsigned len;
    int unsigned pick;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      pick = $urandom_range(0, 99);
      if (hold_req) begin
        hold_req = 1'b0;
        lvl = 1'b0;
        len = LONG_HOLD;
      end else if (pick < 45) begin
        lvl = 1'b1;
        len = $urandom_range(1, 20);
      end else if (pick < 50) begin
        lvl = 1'b1;
        len = $urandom_range(100, 200);
      end else if (pick < 85) begin
        lvl = 1'b0;
        len = $urandom_range(1, 3);
      end else if (pick < 97) begin
        lvl = 1'b0;
        len = $urandom_range(4, 12);
      end else begin
        lvl = 1'b0;
        len = $urandom_range(30, 80);
      end
      out_if.ready <= lvl;
      repeat (len) @(posedge clk_i);
    end
  end

  // Result checker
  initial begin : result_check
    overlap_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (pending_overlaps.size() == 0) begin
          report_error($sformatf("unexpected word overlap=%0d status=%0d",
                                 out_if.overlap, out_if.status));
        end else begin
          e = pending_overlaps.pop_front();
          if (out_if.overlap !== e.ovl) begin
            report_error($sformatf("overlap %0d, want %0d", out_if.overlap, e.ovl));
          end
          if (out_if.status !== e.st) begin
            report_error($sformatf("status %0d, want %0d", out_if.status, e.st));
          end
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int          seq;
    int          kind;
    int          n;
    bit          steady;
    logic [63:0] ones;
    ones = '1;
    want_none = '{'0, ST_OK};
    error_count  = 0;
    words_sent   = 0;
    hold_req     = 1'b0;
    taxa_stored  = 0;
    rows_dropped = 1'b0;
    parts_cfg    = CFG_W'(CFG_RESET);
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_data       <= '0;
    in_if.valid    <= 1'b0;
    in_if.cmd      <= CMD_NONE;
    in_if.row_bits <= '0;
    in_if.part_a   <= '0;
    in_if.part_b   <= '0;

    // Directed table; typed results are read straight off the rules
    add_step(query_step(0, 1, 1, 0, ST_OK));             // empty store
    add_step(query_step(0, 0, 1, 0, ST_OK));
    add_step(query_step(63, 0, 1, 0, ST_OK));
    add_step(cmd_step(CMD_APPEND, ones, 2));
    add_step(cmd_step(CMD_APPEND, '0, 1));
    add_step(query_step(0, 63, 1, 2, ST_OK));
    add_step(query_step(5, 5, 1, 0, ST_OK));             // same partition
    add_step(cmd_step(CMD_NONE, ones, 1));               // unused command
    add_step(cmd_step(CMD_APPEND, 64'h8000_0000_0000_0001, 1));
    add_step(query_step(0, 63, 1, 3, ST_OK));
    add_step(cmd_step(CMD_APPEND, 64'hAAAA_5555_AAAA_5555, 1));
    add_step(query_step(1, 62, 0, 0, ST_OK));
    add_step(cmd_step(CMD_CLEAR, ones, 1));
    add_step(query_step(0, 63, 1, 0, ST_OK));
    add_step(cfg_step(CFG_W'(1)));                       // single partition
    add_step(cmd_step(CMD_APPEND, ones, 1));
    add_step(query_step(0, 1, 1, 0, ST_BAD_INDEX));
    add_step(query_step(0, 0, 1, 0, ST_OK));
    add_step(cfg_step('0));                              // no partition valid
    add_step(query_step(0, 0, 1, 0, ST_BAD_INDEX));
    add_step(cfg_step('1));                              // saturates to 64
    add_step(query_step(0, 63, 0, 0, ST_OK));
    add_step(cmd_step(CMD_CLEAR, '0, 1));
    add_step(cmd_step(CMD_APPEND, ones, MAX_TAXA + 1));  // one row dropped
    add_step(query_step(0, 1, 1, MAX_TAXA, ST_DROPPED));
    add_step(query_step(7, 7, 1, 0, ST_DROPPED));
    add_step(cfg_step(CFG_W'(10)));
    add_step(query_step(0, 20, 1, 0, ST_BAD_INDEX));     // index before drop
    add_step(query_step(2, 9, 1, MAX_TAXA, ST_DROPPED));
    add_step(cmd_step(CMD_CLEAR, '0, 1));
    add_step(query_step(2, 9, 1, 0, ST_OK));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].cfg_row) begin
        write_parts(plan[i].cfg_val);
      end else begin
        repeat (plan[i].reps) begin
          send_word(plan[i].w, plan[i].typed, plan[i].want);
          sender_gap(1'b0);
        end
      end
    end

    // Random command sequences: mostly clear, rows, queries
    seq = 0;
    while (words_sent < RANDOM_WORDS) begin
      seq++;
      steady = ($urandom_range(0, 4) == 0);
      if (seq % 8 == 0) write_parts(pick_cfg());
      if (seq % 11 == 0) settle();
      // receiver backs off while the sender keeps offering
      if (seq == 3 || seq == 20) hold_req = 1'b1;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 8)) begin
          send_word(make_word(cmd_e'($urandom_range(0, 3))), 1'b0, want_none);
          sender_gap(steady);
        end
      end else begin
        // kind 1 keeps the old store and keeps filling it
        if (kind != 1) begin
          send_word(make_word(CMD_CLEAR), 1'b0, want_none);
          sender_gap(steady);
        end
        n = ($urandom_range(0, 14) == 0) ? $urandom_range(MAX_TAXA - 16, MAX_TAXA + 14)
                                         : $urandom_range(0, 24);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) send_word(make_query(), 1'b0, want_none);
          else send_word(make_word(CMD_APPEND), 1'b0, want_none);
          sender_gap(steady);
        end
        repeat ($urandom_range(1, 10)) begin
          send_word(make_query(), 1'b0, want_none);
          sender_gap(steady);
        end
      end
    end

    settle();
    repeat (TAIL_CYC) @(posedge clk_i);
    if (pending_overlaps.size() != 0) begin
      report_error($sformatf("%0d results never arrived", pending_overlaps.size()));
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/pocnt_pkg.sv
rtl/pocnt_in_if.sv
rtl/pocnt_out_if.sv
rtl/pocnt_front.sv
rtl/pocnt_fifo.sv
rtl/pocnt_back.sv
rtl/partition_overlap_counter_top.sv
sim/testbench.sv
